/* rtl/core/lmbcm_pkg.sv */
// ----------------------------------------------------------------------------
// lmbcm_pkg: shared types and constants of the bcm bus word generator
// item layouts, config register map, bus word bit positions, datapath widths
// ----------------------------------------------------------------------------
package lmbcm_pkg;

  // field widths
  localparam int ROW_W   = 4;
  localparam int PLANE_W = 4;
  localparam int IDX_W   = 21;
  localparam int RGB_W   = 6;
  localparam int WORD_W  = 16;

  // config register widths
  localparam int RC_W  = 5;
  localparam int LW_W  = 11;
  localparam int PC_W  = 4;
  localparam int TP_W  = 4;
  localparam int LBW_W = 8;
  localparam int BRI_W = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  // bus word layout
  localparam int GATE_POS = 15;
  localparam int ADDR_POS = 11;
  localparam int LAT_POS  = 9;
  localparam int OE_POS   = 8;
  localparam int ADDR_W   = 4;
  localparam logic [ADDR_W-1:0] ADDR_LOW_BITS = 4'hF;

  // brightness is an 8-bit fraction of the window
  localparam int BRI_SHIFT = 8;

  // datapath widths: weighted padding is line_width << (at most 14)
  localparam int MAX_SHIFT = 14;
  localparam int MD_W   = LW_W + MAX_SHIFT;      // weighted padding
  localparam int PAD_W  = MD_W + 1;              // padding and buffer length
  localparam int PROD_W = LW_W + BRI_W;          // line_width * brightness
  localparam int SH_W   = MD_W + BRI_SHIFT;      // product after plane weight

  // config register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT   = 3'd0,
    CFG_LINE_WIDTH  = 3'd1,
    CFG_PLANE_COUNT = 3'd2,
    CFG_TRANS_PLANE = 3'd3,
    CFG_LATCH_BLANK = 3'd4,
    CFG_BRIGHTNESS  = 3'd5
  } cfg_reg_t;

  // reset values
  localparam logic [RC_W-1:0]  RST_ROW_COUNT   = 5'd16;
  localparam logic [LW_W-1:0]  RST_LINE_WIDTH  = 11'd64;
  localparam logic [PC_W-1:0]  RST_PLANE_COUNT = 4'd8;
  localparam logic [TP_W-1:0]  RST_TRANS_PLANE = 4'd0;
  localparam logic [LBW_W-1:0] RST_LATCH_BLANK = 8'd1;
  localparam logic [BRI_W-1:0] RST_BRIGHTNESS  = 8'd128;

  typedef struct packed {
    logic [RC_W-1:0]  row_count;
    logic [LW_W-1:0]  line_width;
    logic [PC_W-1:0]  plane_count;
    logic [TP_W-1:0]  transition_plane;
    logic [LBW_W-1:0] latch_blank_words;
    logic [BRI_W-1:0] brightness;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [PLANE_W-1:0] plane_index;
    logic [IDX_W-1:0]   word_index;
    logic [RGB_W-1:0]   rgb_bits;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] bus_word;
    logic              last_of_buffer;
    logic              out_of_range;
  } out_item_t;

  // first stage results handed to the word stage
  typedef struct packed {
    logic              oor;
    logic              last;
    logic              pixel;
    logic              lat;
    logic              blank;
    logic [ADDR_W-1:0] addr;
    logic [RGB_W-1:0]  rgb;
    logic [IDX_W-1:0]  pad_pos;
    logic [MD_W-1:0]   md;
    logic [PAD_W-1:0]  pad;
    logic [MD_W-1:0]   win_raw;
  } plan_t;

endpackage

/* rtl/core/lmbcm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lmbcm_cfg_regs: configuration register file
// write-only registers selected by index, reset to the panel defaults
// ----------------------------------------------------------------------------
module lmbcm_cfg_regs
  import lmbcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count         <= RST_ROW_COUNT;
      cfg_r.line_width        <= RST_LINE_WIDTH;
      cfg_r.plane_count       <= RST_PLANE_COUNT;
      cfg_r.transition_plane  <= RST_TRANS_PLANE;
      cfg_r.latch_blank_words <= RST_LATCH_BLANK;
      cfg_r.brightness        <= RST_BRIGHTNESS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:   cfg_r.row_count         <= cfg_wdata[RC_W-1:0];
        CFG_LINE_WIDTH:  cfg_r.line_width        <= cfg_wdata[LW_W-1:0];
        CFG_PLANE_COUNT: cfg_r.plane_count       <= cfg_wdata[PC_W-1:0];
        CFG_TRANS_PLANE: cfg_r.transition_plane  <= cfg_wdata[TP_W-1:0];
        CFG_LATCH_BLANK: cfg_r.latch_blank_words <= cfg_wdata[LBW_W-1:0];
        CFG_BRIGHTNESS:  cfg_r.brightness        <= cfg_wdata[BRI_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/lmbcm_plan.sv */
// ----------------------------------------------------------------------------
// lmbcm_plan: buffer geometry stage
// buffer length, range check, row address and raw oe window for one item
// ----------------------------------------------------------------------------
module lmbcm_plan
  import lmbcm_pkg::*;
(
  input  in_item_t item,
  input  cfg_t     cfg,
  output plan_t    plan
);

  logic              plane_hi;
  logic [PLANE_W-1:0] sh;
  logic [MD_W-1:0]   md;
  logic [PAD_W-1:0]  pad;
  logic [PAD_W-1:0]  total;
  logic [PROD_W-1:0] prod;
  logic [SH_W-1:0]   prod_sh;
  logic [IDX_W-1:0]  lw_ext;
  logic [RC_W-1:0]   rc_m1;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    // weighted padding: line_width << (plane - transition - 1)
    plane_hi = item.plane_index > cfg.transition_plane;
    sh       = item.plane_index - cfg.transition_plane - PLANE_W'(1);
    md       = plane_hi ? (MD_W'(cfg.line_width) << sh) : '0;
    pad      = PAD_W'(cfg.latch_blank_words) + PAD_W'(md);
    total    = pad + PAD_W'(cfg.line_width);

    // window length before clamping: (md * brightness) >> 8
    prod     = PROD_W'(cfg.line_width) * PROD_W'(cfg.brightness);
    prod_sh  = SH_W'(prod) << sh;

    lw_ext   = IDX_W'(cfg.line_width);

    // plane zero shows the previous row while the current one shifts in
    rc_m1 = cfg.row_count - RC_W'(1);
    if (item.plane_index == '0) begin
      if (item.row_index == '0) addr = rc_m1[ADDR_W-1:0];
      else                      addr = item.row_index - ROW_W'(1);
    end else begin
      addr = item.row_index;
    end

    plan.oor     = (RC_W'(item.row_index) >= cfg.row_count)
                || (item.plane_index >= cfg.plane_count)
                || (PAD_W'(item.word_index) >= total);
    plan.last    = PAD_W'(item.word_index) == (total - PAD_W'(1));
    plan.pixel   = item.word_index < lw_ext;
    plan.lat     = item.word_index == (lw_ext - IDX_W'(1));
    plan.blank   = cfg.brightness == '0;
    plan.addr    = addr & ADDR_LOW_BITS;
    plan.rgb     = item.rgb_bits;
    plan.pad_pos = item.word_index - lw_ext;
    plan.md      = md;
    plan.pad     = pad;
    plan.win_raw = plane_hi ? prod_sh[SH_W-1 -: MD_W] : '0;
  end

endmodule

/* rtl/core/lmbcm_word.sv */
// ----------------------------------------------------------------------------
// lmbcm_word: bus word stage
// clamps and centres the oe window and packs the 16-bit bus word
// ----------------------------------------------------------------------------
module lmbcm_word
  import lmbcm_pkg::*;
(
  input  plan_t     plan,
  output out_item_t res
);

  logic [MD_W-1:0]   win_min;
  logic [MD_W-1:0]   md_m1;
  logic [MD_W-1:0]   win;
  logic [PAD_W-1:0]  start;
  logic [PAD_W-1:0]  pos;
  logic              lit;
  logic              oe_pad;
  logic [WORD_W-1:0] word;

  always_comb begin
    win_min = (plan.win_raw == '0) ? MD_W'(1) : plan.win_raw;
    md_m1   = plan.md - MD_W'(1);
    win     = (win_min > md_m1) ? md_m1 : win_min;
    start   = (plan.pad - PAD_W'(win)) >> 1;
    pos     = PAD_W'(plan.pad_pos);
    lit     = (pos >= start) && (pos < start + PAD_W'(win));

    // latch tail, too short a window, zero brightness or a position outside the window keep oe high
    oe_pad  = plan.blank || (pos >= PAD_W'(plan.md)) || (plan.md <= MD_W'(1)) || !lit;

    word = '0;
    word[ADDR_POS +: ADDR_W] = plan.addr;
    if (plan.pixel) begin
      word[GATE_POS]      = 1'b1;
      word[OE_POS]        = 1'b1;
      word[LAT_POS]       = plan.lat;
      word[RGB_W-1:0]     = plan.rgb;
    end else begin
      word[OE_POS]        = oe_pad;
    end

    if (plan.oor) begin
      res.bus_word       = '0;
      res.last_of_buffer = 1'b0;
      res.out_of_range   = 1'b1;
    end else begin
      res.bus_word       = word;
      res.last_of_buffer = plan.last;
      res.out_of_range   = 1'b0;
    end
  end

endmodule

/* rtl/core/led_matrix_bcm_word_generator.sv */
// ----------------------------------------------------------------------------
// led_matrix_bcm_word_generator: bcm bus word generator for a two-scan panel
// one 16-bit parallel bus word per item, chosen by row, plane and word index
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one item = row, bit plane, word index and six colour bits
//   out_* : one item = bus word, last-of-buffer flag, out-of-range flag
//   cfg_* : write-only registers (row count, line width, plane count,
//           transition plane, latch blank words, brightness), written by
//           index while no item is in flight
//   path: an accepted item is held in the input register, passes the
//     geometry and word logic and is captured in the result register,
//     which drives out_valid and out_data
//   throughput: 1 item per cycle while out_stall is low, both registers advancing
//   stall: out_stall holds the result register; the input register keeps
//     filling until both are full, only then in_stall rises
//   reset: rst_n (synchronous) empties the pipeline and loads the default
//     panel geometry; no clearing pass is needed
// ----------------------------------------------------------------------------
module led_matrix_bcm_word_generator
  import lmbcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // item input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;

  // pipeline registers
  logic      s1_vld_r;
  in_item_t  s1_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;

  plan_t     plan_nxt;
  out_item_t res_nxt;

  // stage enables: a stage loads when it is empty or its contents move on
  logic      en_out;
  logic      en_s1;

  lmbcm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // geometry: buffer length, range, address, raw window
  lmbcm_plan u_plan (
    .item (s1_item_r),
    .cfg  (cfg),
    .plan (plan_nxt)
  );

  // window placement and word packing
  lmbcm_word u_word (
    .plan (plan_nxt),
    .res  (res_nxt)
  );

  assign en_out = !out_vld_r || !out_stall;
  assign en_s1  = !s1_vld_r || en_out;

  // valid bits are control state and get reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en_s1)  s1_vld_r  <= in_valid;
      if (en_out) out_vld_r <= s1_vld_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en_s1)  s1_item_r  <= in_data;
    if (en_out) out_item_r <= res_nxt;
  end

  assign in_stall  = !en_s1;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
